// File: hdl/lurs_pkg.sv
// Shared types and constants for the LCG uniform range sampler.
// Has no dependencies. The controller, the datapath and the top level import it.
`timescale 1ns / 1ps

package lurs_pkg;

  // Status codes carried by a result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SPAN  = 2'd2;

  // Register index (bit 2 of the byte address)
  localparam logic REG_SEED = 1'b0;

  // Generator constants
  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam int          DRAW_SHIFT = 16;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_LIM   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_ADV   = 8'b0001_0000,
    S_TEST  = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ld_req;   // capture the request bounds
    logic chk;      // latch range status, start the limit remainder
    logic step;     // one remainder step
    logic ld_lim;   // latch the rejection limit
    logic mul;      // register state * multiplier
    logic adv;      // add the increment, update the state
    logic start_mod; // start draw mod modulus
    logic ld_out;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fail;     // low bound not below high bound, or range too wide
    logic rej;      // current draw lies above the limit
    logic last;     // final remainder step
  } stat_t;

endpackage

// File: hdl/lcg_uniform_range_sampler.sv
// Top level of the LCG uniform range sampler: ports, APB decode, assertions.
// Depends on lurs_pkg, lurs_ctrl and lurs_dp.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: range_low and
//   range_high, both inclusive bounds. The result channel (out_valid/out_stall)
//   returns exactly one result per request: out_value and out_status
//   (0 ok, 1 range_low not below range_high, 2 span wider than a draw).
//   The seed register (byte address 0) sets the generator state when written;
//   write it only while no request is in flight.
// Timing:
//   An error request goes through S_CHECK and S_DONE before out_valid rises; a
//   valid one goes through S_CHECK, S_LIM, then S_MUL, S_ADV and S_TEST once per
//   draw (at least half of all draws pass), then S_MOD and S_DONE. The
//   bit-serial remainder unit dominates: one pass for the limit, one for the
//   accepted draw. Only one request is worked on at a time; the next is accepted
//   in S_IDLE once the result has been loaded.
// Reset: synchronous, active low; clear the seed, the generator state and any pending result.
// Stall: hold a pending result on the out_ ports while out_stall is high; a new request may
//   still be accepted and worked on, finishing once the result register frees.
`timescale 1ns / 1ps

module lcg_uniform_range_sampler
  import lurs_pkg::*;
#(
  parameter int DRAW_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  // Zero-wait port: write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  lurs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lurs_dp #(
    .DRAW_BITS (DRAW_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .cfg_wr        (cfg_wr),
    .cfg_idx       (paddr[2]),
    .cfg_wdata     (pwdata),
    .cfg_rdata     (prdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  // An accepted request blocks further requests in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while busy");

  // Status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EMPTY ||
                   out_status == ST_SPAN))
    else $error("undefined status code");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

// File: hdl/lurs_ctrl.sv
// Sequencing state machine of the sampler: handshakes and draw loop.
// Depends on lurs_pkg; drives lurs_dp through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module lurs_ctrl
  import lurs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_free;

  assign out_free  = !ovalid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.fail ? S_DONE : S_LIM;
      end
      S_LIM: begin
        cmd.step = 1'b1;
        if (stat.last) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cmd.ld_lim = 1'b1;
        state_nxt  = S_ADV;
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.rej) begin
          state_nxt = S_MUL;
        end else begin
          cmd.start_mod = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        cmd.step = 1'b1;
        if (stat.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// File: hdl/lurs_dp.sv
// Datapath of the sampler: seed register, LCG, shared remainder unit, result.
// Depends on lurs_pkg; commanded by lurs_ctrl.
`timescale 1ns / 1ps

module lurs_dp
  import lurs_pkg::*;
#(
  parameter int DRAW_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  input  logic        cfg_wr,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_rdata,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [31:0] out_value,
  output logic [1:0]  out_status
);

  localparam int DW = DRAW_BITS + 1;
  localparam int CW = $clog2(DW);
  localparam logic [31:0] DRAW_MAX = 32'((64'd1 << DRAW_BITS) - 64'd1);

  logic [31:0]          seed_r, seed_nxt;
  logic [31:0]          lcg_r, lcg_nxt;
  logic [31:0]          prod_r;
  logic [31:0]          lo_r, hi_r;
  logic [1:0]           st_r;
  logic [DW-1:0]        mod_r, div_r, div_nxt, rem_r, rem_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DRAW_BITS-1:0] lim_r, draw;
  logic [31:0]          val_r;
  logic [1:0]           ost_r;
  logic [31:0]          span;
  logic                 inv, wide;
  logic [DW:0]          sh, diff;

  assign span = hi_r - lo_r;
  assign inv  = (lo_r >= hi_r);
  assign wide = (span > DRAW_MAX);
  assign draw = lcg_r[DRAW_SHIFT+DRAW_BITS-1:DRAW_SHIFT];

  assign stat.fail = inv || wide;
  assign stat.rej  = (draw > lim_r);
  assign stat.last = (cnt_r == '0);

  // Restoring remainder step: shift in one dividend bit, subtract if it fits
  assign sh   = {rem_r, div_r[DW-1]};
  assign diff = sh - {1'b0, mod_r};

  always_comb begin
    rem_nxt = rem_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (cmd.chk) begin
      rem_nxt = '0;
      div_nxt = DW'(1) << DRAW_BITS;
      cnt_nxt = CW'(DW - 1);
    end else if (cmd.start_mod) begin
      rem_nxt = '0;
      div_nxt = {1'b0, draw};
      cnt_nxt = CW'(DW - 1);
    end else if (cmd.step) begin
      rem_nxt = (sh >= {1'b0, mod_r}) ? diff[DW-1:0] : sh[DW-1:0];
      div_nxt = {div_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    seed_nxt = seed_r;
    lcg_nxt  = lcg_r;
    if (cfg_wr && cfg_idx == REG_SEED) begin
      seed_nxt = cfg_wdata;
      lcg_nxt  = cfg_wdata;
    end else if (cmd.adv) begin
      lcg_nxt = prod_r + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      lcg_r  <= '0;
    end else begin
      seed_r <= seed_nxt;
      lcg_r  <= lcg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.ld_req) begin
      lo_r <= in_range_low;
      hi_r <= in_range_high;
    end
    if (cmd.chk) begin
      st_r  <= inv ? ST_EMPTY : (wide ? ST_SPAN : ST_OK);
      mod_r <= span[DRAW_BITS:0] + DW'(1);
    end
    if (cmd.ld_lim) lim_r <= DRAW_MAX[DRAW_BITS-1:0] - rem_r[DRAW_BITS-1:0];
    if (cmd.mul) prod_r <= lcg_r * LCG_MUL;
    if (cmd.ld_out) begin
      val_r <= (st_r == ST_OK) ? lo_r + {{(32-DW){1'b0}}, rem_r} : hi_r;
      ost_r <= st_r;
    end
  end

  assign cfg_rdata  = seed_r;
  assign out_value  = val_r;
  assign out_status = ost_r;

endmodule
